/* design/charge_current_spec_selector_unit_macros.svh */
// ---------------------------------------------------------------------------
// Charge current spec selector - assertion macros
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CHARGE_CURRENT_SPEC_SELECTOR_UNIT_MACROS_SVH
`define CHARGE_CURRENT_SPEC_SELECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define CCSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccss assertion failed");

// next-cycle implication
`define CCSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccss assertion failed");

`endif

/* design/ccss_pkg.sv */
// ---------------------------------------------------------------------------
// Charge current spec selector - package
// Entry layout, codes, hysteresis constants and controller/datapath structs.
// ---------------------------------------------------------------------------
package ccss_pkg;

  localparam logic [2:0] NO_MATCH = 3'd6;
  localparam logic [2:0] NONE_YET = 3'd7;

  localparam logic signed [9:0] TEMP_HYST = 10'sd2;
  localparam logic [16:0]       VOLT_HYST = 17'd200;

  localparam logic [2:0] REG_ENTRY0   = 3'd0;
  localparam logic [2:0] REG_ENTRY1   = 3'd1;
  localparam logic [2:0] REG_ENTRY2   = 3'd2;
  localparam logic [2:0] REG_ENTRY3   = 3'd3;
  localparam logic [2:0] REG_COUNT    = 3'd4;
  localparam logic [2:0] REG_FLOAT    = 3'd5;
  localparam logic [2:0] REG_STEP_CUR = 3'd6;
  localparam logic [2:0] REG_STEP_PER = 3'd7;

  localparam logic OP_MEAS = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [15:0]        curr;
    logic [15:0]        volt;
    logic signed [7:0]  tmax;
    logic signed [7:0]  tmin;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic take_t;
    logic take_c;
    logic scan;
    logic decide;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic eff_zero;
    logic scan_last;
  } ctrl_sts_t;

endpackage

/* design/ccss_in_if.sv */
// ---------------------------------------------------------------------------
// Charge current spec selector - measurement channel
// Valid/ready channel carrying one measurement or millisecond tick request.
// ---------------------------------------------------------------------------
interface ccss_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [7:0] temperature;
  logic [15:0]       voltage;
  logic              chg_present;

  modport source (output valid, output op, output temperature, output voltage,
                  output chg_present, input ready);
  modport sink   (input valid, input op, input temperature, input voltage,
                  input chg_present, output ready);
endinterface

/* design/ccss_out_if.sv */
// ---------------------------------------------------------------------------
// Charge current spec selector - vote channel
// Valid/ready channel carrying one vote result request.
// ---------------------------------------------------------------------------
interface ccss_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] current_vote;
  logic        vote_made;
  logic [2:0]  selected_entry;

  modport source (output valid, output current_vote, output vote_made,
                  output selected_entry, input ready);
  modport sink   (input valid, input current_vote, input vote_made,
                  input selected_entry, output ready);
endinterface

/* design/charge_current_spec_selector_unit.sv */
// ---------------------------------------------------------------------------
// Charge current spec selector - top level
// A request is taken only while the controller is idle, so requests are handled
// one at a time. A measurement scans the entries in use through the single read
// port of the entry memory; a tick, or a measurement with the table disabled,
// skips the scan.
// Reset clears config registers, entry valid bits and selector state at once.
// ---------------------------------------------------------------------------
`include "charge_current_spec_selector_unit_macros.svh"

module charge_current_spec_selector_unit #(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic        clk,
  input  logic        rst,
  ccss_in_if.sink     meas,
  ccss_out_if.source  vote,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  ccss_pkg::ctrl_cmd_t cmd;
  ccss_pkg::ctrl_sts_t sts;

  ccss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas.valid),
    .meas_ready (meas.ready),
    .vote_valid (vote.valid),
    .vote_ready (vote.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ccss_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .op             (meas.op),
    .temperature    (meas.temperature),
    .voltage        (meas.voltage),
    .chg_present    (meas.chg_present),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .current_vote   (vote.current_vote),
    .vote_made      (vote.vote_made),
    .selected_entry (vote.selected_entry)
  );

  `CCSS_ASSERT_NEXT(a_busy_after_take, meas.valid && meas.ready, !meas.ready)
  `CCSS_ASSERT_NEXT(a_commit_shows, cmd.commit, vote.valid)
  `CCSS_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0({cmd.take_t, cmd.take_c, cmd.scan, cmd.decide, cmd.commit}))

endmodule

/* design/ccss_ctrl.sv */
// ---------------------------------------------------------------------------
// Charge current spec selector - controller
// Sequences entry fetches, table scan, decision and commit of one request.
// ---------------------------------------------------------------------------
module ccss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                meas_valid,
  output logic                meas_ready,
  output logic                vote_valid,
  input  logic                vote_ready,
  input  ccss_pkg::ctrl_sts_t sts,
  output ccss_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {IDLE, FETCH_T, FETCH_C, SCAN, DECIDE, COMMIT} state_t;

  state_t state, state_next;
  logic   commit_ok;

  assign meas_ready = (state == IDLE);
  assign commit_ok  = (state == COMMIT) && (!vote_valid || vote_ready);

  always_comb begin
    cmd        = '0;
    cmd.latch  = meas_valid && meas_ready;
    cmd.take_t = (state == FETCH_T);
    cmd.take_c = (state == FETCH_C);
    cmd.scan   = (state == SCAN);
    cmd.decide = (state == DECIDE);
    cmd.commit = commit_ok;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:    if (meas_valid) state_next = FETCH_T;
      FETCH_T: state_next = FETCH_C;
      FETCH_C: begin
        if (sts.op_tick || sts.eff_zero) state_next = COMMIT;
        else state_next = SCAN;
      end
      SCAN:    if (sts.scan_last) state_next = DECIDE;
      DECIDE:  state_next = COMMIT;
      COMMIT:  if (commit_ok) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      vote_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_ok) vote_valid <= 1'b1;
      else if (vote_ready) vote_valid <= 1'b0;
    end
  end

endmodule

/* design/ccss_datapath.sv */
// ---------------------------------------------------------------------------
// Charge current spec selector - datapath
// Config registers, entry memory, scan, hysteresis decision and step-down.
// ---------------------------------------------------------------------------
module ccss_datapath #(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  ccss_pkg::ctrl_cmd_t cmd,
  output ccss_pkg::ctrl_sts_t sts,
  input  logic                op,
  input  logic signed [7:0]   temperature,
  input  logic [15:0]         voltage,
  input  logic                chg_present,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output logic [15:0]         current_vote,
  output logic                vote_made,
  output logic [2:0]          selected_entry
);

  localparam int         IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [2:0] DEPTH = 3'(TABLE_ENTRIES);

  // configuration
  logic [2:0]  table_count;
  logic [15:0] float_voltage, step_current, step_period;
  logic [2:0]  eff;

  // entry memory
  ccss_pkg::entry_t   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ent_valid;
  ccss_pkg::entry_t   rdata_raw, rdata;
  logic               rd_ok;
  logic [2:0]         rcode;
  logic [IDX_W-1:0]   raddr;
  logic               cfg_ent;

  // item and block state
  logic              op_q, online_q;
  logic signed [7:0] temp_q;
  logic [15:0]       volt_q;
  logic [2:0]        target_entry, step_entry;
  logic [15:0]       last_vote, tick_countdown;
  logic              step_pending;

  ccss_pkg::entry_t t_ent, cur_ent, sel_ent, tgt_ent;
  logic [2:0]  cnt, sel, tgt_code;
  logic        found, update_q, upd, match;
  logic [15:0] fcc;

  assign eff     = (table_count < DEPTH) ? table_count : DEPTH;
  assign cfg_ent = cfg_we && (cfg_index < DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count   <= '0;
      float_voltage <= '0;
      step_current  <= '0;
      step_period   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccss_pkg::REG_COUNT:    table_count   <= cfg_data[2:0];
        ccss_pkg::REG_FLOAT:    float_voltage <= cfg_data[15:0];
        ccss_pkg::REG_STEP_CUR: step_current  <= cfg_data[15:0];
        ccss_pkg::REG_STEP_PER: step_period   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ent_valid <= '0;
    else if (cfg_ent) ent_valid[cfg_index[IDX_W-1:0]] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cfg_ent) mem[cfg_index[IDX_W-1:0]] <= ccss_pkg::entry_t'(cfg_data);
  end

  always_comb begin
    priority if (cmd.latch) rcode = target_entry;
    else if (cmd.take_t)    rcode = step_entry;
    else if (cmd.scan)      rcode = cnt + 3'd1;
    else                    rcode = 3'd0;
  end

  assign raddr = (rcode < DEPTH) ? rcode[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    rdata_raw <= mem[raddr];
    rd_ok     <= ent_valid[raddr];
  end

  assign rdata = rd_ok ? rdata_raw : '0;

  // latch, fetch and scan
  assign match = (temp_q >= rdata.tmin) && (temp_q < rdata.tmax) && (volt_q <= rdata.volt);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= op;
      temp_q   <= temperature;
      volt_q   <= (voltage > float_voltage) ? float_voltage : voltage;
      online_q <= chg_present;
    end
    if (cmd.take_t) t_ent <= rdata;
    if (cmd.take_c) begin
      cur_ent  <= rdata;
      cnt      <= 3'd0;
      found    <= 1'b0;
      sel      <= ccss_pkg::NO_MATCH;
      update_q <= 1'b0;
    end
    if (cmd.scan) begin
      cnt <= cnt + 3'd1;
      if (!found && match) begin
        found   <= 1'b1;
        sel     <= cnt;
        sel_ent <= rdata;
      end
    end
    if (cmd.decide) update_q <= upd;
  end

  assign sts.op_tick   = (op_q == ccss_pkg::OP_TICK);
  assign sts.eff_zero  = (eff == 3'd0);
  assign sts.scan_last = (cnt == eff - 3'd1);

  // hysteresis decision
  logic signed [9:0] temp_w, tmin_w, tmax_w;
  logic              t_valid;

  assign fcc     = found ? sel_ent.curr : 16'd0;
  assign t_valid = target_entry < eff;
  assign temp_w  = {{2{temp_q[7]}}, temp_q};
  assign tmin_w  = {{2{sel_ent.tmin[7]}}, sel_ent.tmin};
  assign tmax_w  = {{2{sel_ent.tmax[7]}}, sel_ent.tmax};

  always_comb begin
    upd = 1'b0;
    if (sel != target_entry) begin
      priority if (!t_valid || (fcc <= t_ent.curr) || !online_q) begin
        upd = 1'b1;
      end else if ((sel_ent.tmin == t_ent.tmin) && (sel_ent.tmax == t_ent.tmax)) begin
        upd = ({1'b0, volt_q} + ccss_pkg::VOLT_HYST) <= {1'b0, sel_ent.volt};
      end else begin
        upd = (temp_w <= tmax_w - ccss_pkg::TEMP_HYST) &&
              (temp_w >= tmin_w + ccss_pkg::TEMP_HYST);
      end
    end
  end

  // step-down evaluation
  logic               tgt_valid, cur_valid, diff_lt, step_en;
  logic signed [16:0] diff;
  logic [15:0]        se_fcc, se_tfcc, se_count;
  logic [2:0]         se_step;
  logic               se_pending;

  assign tgt_code  = op_q ? target_entry : sel;
  assign tgt_ent   = op_q ? t_ent : sel_ent;
  assign tgt_valid = tgt_code < eff;
  assign cur_valid = step_entry < eff;
  assign diff      = $signed({1'b0, last_vote}) - $signed({1'b0, step_current});
  assign diff_lt   = diff < $signed({1'b0, tgt_ent.curr});
  assign step_en   = (step_current != 16'd0) && (step_period != 16'd0);

  always_comb begin
    se_tfcc = '0;
    se_fcc  = '0;
    if (tgt_valid) begin
      se_tfcc = tgt_ent.curr;
      se_fcc  = last_vote;
      priority if (!cur_valid || !online_q ||
                   ((cur_ent.tmin != tgt_ent.tmin) && (cur_ent.tmax != tgt_ent.tmax))) begin
        se_fcc = tgt_ent.curr;
      end else if ((last_vote > tgt_ent.curr) && (volt_q >= cur_ent.volt)) begin
        se_fcc = diff_lt ? tgt_ent.curr : diff[15:0];
      end else begin
        se_fcc = last_vote;
      end
    end
  end

  assign se_step    = (se_fcc <= se_tfcc) ? tgt_code : step_entry;
  assign se_pending = (se_step != tgt_code);
  assign se_count   = se_pending ? step_period : 16'd0;

  // commit
  logic [2:0]  target_next, step_next;
  logic [15:0] last_vote_next, countdown_next;
  logic        pending_next, voted;

  always_comb begin
    target_next    = target_entry;
    step_next      = step_entry;
    last_vote_next = last_vote;
    countdown_next = tick_countdown;
    pending_next   = step_pending;
    voted          = 1'b0;
    if (op_q == ccss_pkg::OP_MEAS) begin
      if (update_q) begin
        target_next = sel;
        if (!step_en) begin
          last_vote_next = fcc;
          voted          = 1'b1;
        end else if (!step_pending) begin
          last_vote_next = se_fcc;
          step_next      = se_step;
          pending_next   = se_pending;
          countdown_next = se_count;
          voted          = 1'b1;
        end
      end
    end else if (step_pending) begin
      if (tick_countdown <= 16'd1) begin
        last_vote_next = se_fcc;
        step_next      = se_step;
        pending_next   = se_pending;
        countdown_next = se_count;
        voted          = 1'b1;
      end else begin
        countdown_next = tick_countdown - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_entry   <= ccss_pkg::NONE_YET;
      step_entry     <= ccss_pkg::NONE_YET;
      last_vote      <= '0;
      tick_countdown <= '0;
      step_pending   <= 1'b0;
    end else if (cmd.commit) begin
      target_entry   <= target_next;
      step_entry     <= step_next;
      last_vote      <= last_vote_next;
      tick_countdown <= countdown_next;
      step_pending   <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      current_vote   <= last_vote_next;
      vote_made      <= voted;
      selected_entry <= target_next;
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Charge current spec selector - self-checking testbench
// Programs several spec tables and step settings, drives measurement and
// millisecond tick requests in random bursts against a stalling vote sink, and
// checks every vote against a cycle-free model of the selection, hysteresis
// and step-down behaviour.
// ----------------------------------------------------------------------------
module tb_top;
  import ccss_pkg::*;

  localparam int TEMP_MARGIN       = int'(TEMP_HYST);
  localparam int VOLT_MARGIN       = int'(VOLT_HYST);
  localparam int LONG_STALL_AT     = 900;
  localparam int LONG_STALL_CYCLES = 600;
  localparam int REPORT_LIMIT      = 10;
  localparam int RANDOM_PHASES     = 8;

  typedef struct {
    logic              op;
    logic signed [7:0] temperature;
    logic [15:0]       voltage;
    logic              chg_present;
  } spec_req_t;

  typedef struct packed {
    logic [15:0] current_vote;
    logic        vote_made;
    logic [2:0]  selected_entry;
  } vote_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  ccss_in_if  meas_ch ();
  ccss_out_if vote_ch ();

  charge_current_spec_selector_unit #(.TABLE_ENTRIES(4)) uut (
    .clk       (clk),
    .rst       (rst),
    .meas      (meas_ch),
    .vote      (vote_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // programmed settings as seen by the selector model
  entry_t      spec_tbl [4];
  logic [2:0]  spec_count;
  logic [15:0] float_mv;
  logic [15:0] step_ma;
  logic [15:0] step_ms;

  // selector model state
  logic [2:0]  tgt_entry;
  logic [2:0]  stp_entry;
  logic [15:0] last_ma;
  logic [15:0] tick_left;
  bit          step_armed;

  entry_t      work_tbl [4];
  spec_req_t   pending_reqs [$];
  vote_rec_t   expected_votes [$];
  spec_req_t   head_req;
  vote_rec_t   got_vote;
  vote_rec_t   want_vote;

  int meas_taken;
  int ticks_taken;
  int reqs_taken;
  int votes_seen;
  int fail_count;
  int settings_used;
  int burst_left;
  int gap_left;
  int rx_pos;
  int stall_left;
  bit stall_done;
  int phase_no;
  logic [15:0] rx_mask;

  function automatic int eff_entries();
    return (spec_count < 3'd4) ? int'(spec_count) : 4;
  endfunction

  function automatic bit slot_live(logic [2:0] i);
    return int'(i) < eff_entries();
  endfunction

  function automatic int band_lo(logic [2:0] i);
    return int'($signed(spec_tbl[i[1:0]].tmin));
  endfunction

  function automatic int band_hi(logic [2:0] i);
    return int'($signed(spec_tbl[i[1:0]].tmax));
  endfunction

  function automatic int ceil_mv(logic [2:0] i);
    return int'(spec_tbl[i[1:0]].volt);
  endfunction

  function automatic int supply_ma(logic [2:0] i);
    return int'(spec_tbl[i[1:0]].curr);
  endfunction

  function automatic void step_toward_target(int mv, logic online);
    int want;
    int have;
    want = 0;
    have = 0;
    if (slot_live(tgt_entry)) begin
      want = supply_ma(tgt_entry);
      have = int'(last_ma);
      if (!slot_live(stp_entry) || !online ||
          (band_lo(stp_entry) != band_lo(tgt_entry) &&
           band_hi(stp_entry) != band_hi(tgt_entry))) begin
        have = want;
      end else if (have > want && mv >= ceil_mv(stp_entry)) begin
        have = have - int'(step_ma);
        if (have < want) have = want;
      end
    end
    last_ma = have[15:0];
    if (have <= want) stp_entry = tgt_entry;
    if (stp_entry == tgt_entry) begin
      step_armed = 1'b0;
      tick_left  = '0;
    end else begin
      step_armed = 1'b1;
      tick_left  = step_ms;
    end
  endfunction

  function automatic vote_rec_t predict_vote(spec_req_t rq);
    int         t_c;
    int         mv;
    int         fcc;
    int         i;
    logic [2:0] sel;
    logic [2:0] prev;
    bit         voted;
    bit         upd;
    bit         hit;
    vote_rec_t  res;
    t_c   = int'(rq.temperature);
    mv    = (rq.voltage > float_mv) ? int'(float_mv) : int'(rq.voltage);
    voted = 1'b0;
    upd   = 1'b0;
    if (rq.op == OP_TICK) begin
      if (step_armed) begin
        if (tick_left <= 16'd1) begin
          step_toward_target(mv, rq.chg_present);
          voted = 1'b1;
        end else begin
          tick_left = tick_left - 16'd1;
        end
      end
    end else if (eff_entries() > 0) begin
      sel = NO_MATCH;
      fcc = 0;
      hit = 1'b0;
      for (i = 0; i < eff_entries(); i++) begin
        if (!hit && t_c >= band_lo(3'(i)) && t_c < band_hi(3'(i)) &&
            mv <= ceil_mv(3'(i))) begin
          sel = 3'(i);
          fcc = supply_ma(3'(i));
          hit = 1'b1;
        end
      end
      if (sel != tgt_entry) begin
        prev = tgt_entry;
        if (!slot_live(prev) || fcc <= supply_ma(prev) || !rq.chg_present) begin
          upd = 1'b1;
        end else if (band_lo(sel) == band_lo(prev) && band_hi(sel) == band_hi(prev)) begin
          upd = !(mv > ceil_mv(sel) - VOLT_MARGIN);
        end else begin
          upd = !(t_c > band_hi(sel) - TEMP_MARGIN || t_c < band_lo(sel) + TEMP_MARGIN);
        end
      end
      if (upd) begin
        tgt_entry = sel;
        if (step_ma != 16'd0 && step_ms != 16'd0) begin
          if (!step_armed) begin
            step_toward_target(mv, rq.chg_present);
            voted = 1'b1;
          end
        end else begin
          last_ma = fcc[15:0];
          voted   = 1'b1;
        end
      end
    end
    res.current_vote   = last_ma;
    res.vote_made      = voted;
    res.selected_entry = tgt_entry;
    return res;
  endfunction

  function automatic entry_t mk_entry(int lo, int hi, int mv, int ma);
    entry_t e;
    e.tmin = lo[7:0];
    e.tmax = hi[7:0];
    e.volt = mv[15:0];
    e.curr = ma[15:0];
    return e;
  endfunction

  function automatic void queue_req(logic op, int t, int mv, logic online);
    spec_req_t rq;
    rq.op          = op;
    rq.temperature = t[7:0];
    rq.voltage     = mv[15:0];
    rq.chg_present = online;
    pending_reqs.push_back(rq);
  endfunction

  // aim most requests at band edges and ceilings of the programmed table
  function automatic void queue_random();
    logic [2:0] k;
    logic       op;
    logic       online;
    int         t;
    int         mv;
    k      = 3'($urandom_range(0, 3));
    op     = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_MEAS;
    online = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 3) == 0) begin
      t = int'($urandom_range(0, 255)) - 128;
    end else begin
      t = ($urandom_range(0, 1) ? band_hi(k) : band_lo(k)) + int'($urandom_range(0, 6)) - 3;
      if (t > 127) t = 127;
      if (t < -128) t = -128;
    end
    if ($urandom_range(0, 4) == 0) begin
      mv = int'($urandom_range(0, 65535));
    end else begin
      mv = ceil_mv(k) + int'($urandom_range(0, 500)) - 300;
      if (mv < 0) mv = 0;
      if (mv > 65535) mv = 65535;
    end
    queue_req(op, t, mv, online);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ENTRY0:   spec_tbl[0] = val;
      REG_ENTRY1:   spec_tbl[1] = val;
      REG_ENTRY2:   spec_tbl[2] = val;
      REG_ENTRY3:   spec_tbl[3] = val;
      REG_COUNT:    spec_count  = val[2:0];
      REG_FLOAT:    float_mv    = val[15:0];
      REG_STEP_CUR: step_ma     = val[15:0];
      REG_STEP_PER: step_ms     = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_block(input logic [2:0] cnt, input logic [15:0] fv,
                               input logic [15:0] sc, input logic [15:0] sp);
    write_reg(REG_ENTRY0, work_tbl[0]);
    write_reg(REG_ENTRY1, work_tbl[1]);
    write_reg(REG_ENTRY2, work_tbl[2]);
    write_reg(REG_ENTRY3, work_tbl[3]);
    write_reg(REG_COUNT, {45'd0, cnt});
    write_reg(REG_FLOAT, {32'd0, fv});
    write_reg(REG_STEP_CUR, {32'd0, sc});
    write_reg(REG_STEP_PER, {32'd0, sp});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // drain every request and vote, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || meas_ch.valid || expected_votes.size() != 0)
      @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_phase(input int k);
    int a;
    int b;
    int c;
    int d;
    int n;
    a = int'($urandom_range(0, 30)) - 20;
    b = a + int'($urandom_range(3, 20));
    c = b + int'($urandom_range(8, 35));
    d = c + int'($urandom_range(3, 20));
    work_tbl[0] = mk_entry(a, b, $urandom_range(3900, 4400), $urandom_range(100, 1500));
    work_tbl[1] = mk_entry(b, c, $urandom_range(4000, 4200), $urandom_range(1500, 3000));
    work_tbl[2] = mk_entry(b, c, $urandom_range(4200, 4450), $urandom_range(500, 1500));
    work_tbl[3] = mk_entry((k % 2) ? b : c, d, $urandom_range(4000, 4200),
                           $urandom_range(200, 1200));
    n = 280;
    case (k)
      0: program_block(3'd4, 16'd4350, 16'd0, 16'd0);
      1: program_block(3'd4, 16'd4400, 16'd200, 16'd2);
      2: program_block(3'd3, 16'd4300, 16'hFFFF, 16'd4);
      3: program_block(3'd4, 16'd4450, 16'd100, 16'd0);
      4: begin
        program_block(3'd0, 16'd4350, 16'd150, 16'd1);
        n = 60;
      end
      5: program_block(3'd1, 16'hFFFF, 16'd300, 16'd3);
      6: program_block(3'd2, 16'd0, 16'd1, 16'hFFFF);
      default: begin
        work_tbl[1] = {16'($urandom), 32'($urandom)};
        work_tbl[3] = {16'($urandom), 32'($urandom)};
        program_block(3'd4, 16'($urandom), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 4)));
      end
    endcase
    @(negedge clk);
    repeat (n) queue_random();
    settle();
  endtask

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      meas_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (meas_ch.valid && meas_ch.ready) begin
        head_req = pending_reqs.pop_front();
        expected_votes.push_back(predict_vote(head_req));
        reqs_taken <= reqs_taken + 1;
        if (head_req.op == OP_TICK) ticks_taken <= ticks_taken + 1;
        else meas_taken <= meas_taken + 1;
      end
      if (meas_ch.valid && !meas_ch.ready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        gap_left--;
        meas_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        meas_ch.valid       <= 1'b1;
        meas_ch.op          <= pending_reqs[0].op;
        meas_ch.temperature <= pending_reqs[0].temperature;
        meas_ch.voltage     <= pending_reqs[0].voltage;
        meas_ch.chg_present <= pending_reqs[0].chg_present;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                     (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) :
                                                    $urandom_range(1, 4));
      end else begin
        meas_ch.valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off while requests keep coming
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && reqs_taken >= LONG_STALL_AT) begin
      stall_left <= LONG_STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // vote monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      vote_ch.ready <= 1'b0;
      rx_pos  = 0;
      rx_mask = '1;
    end else begin
      if (vote_ch.valid && vote_ch.ready) begin
        got_vote.current_vote   = vote_ch.current_vote;
        got_vote.vote_made      = vote_ch.vote_made;
        got_vote.selected_entry = vote_ch.selected_entry;
        if (got_vote.vote_made === 1'b1) votes_seen++;
        if (expected_votes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: vote %0d/%0b/%0d with no request outstanding", $realtime,
                     got_vote.current_vote, got_vote.vote_made, got_vote.selected_entry);
        end else begin
          want_vote = expected_votes.pop_front();
          if (got_vote.current_vote !== want_vote.current_vote ||
              got_vote.vote_made !== want_vote.vote_made ||
              got_vote.selected_entry !== want_vote.selected_entry) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: vote mismatch, expected %0d/%0b/%0d got %0d/%0b/%0d",
                       $realtime, want_vote.current_vote, want_vote.vote_made,
                       want_vote.selected_entry, got_vote.current_vote,
                       got_vote.vote_made, got_vote.selected_entry);
          end
        end
      end
      if (rx_pos == 0) begin
        case ($urandom_range(0, 3))
          0: rx_mask = '1;
          1: rx_mask = 16'($urandom);
          2: rx_mask = 16'($urandom) | 16'($urandom);
          default: rx_mask = 16'($urandom) & 16'($urandom);
        endcase
      end
      vote_ch.ready <= (stall_left == 0) && rx_mask[rx_pos];
      rx_pos = (rx_pos + 1) % 16;
    end
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_ENTRY0;
    cfg_data            = '0;
    meas_ch.valid       = 1'b0;
    meas_ch.op          = OP_MEAS;
    meas_ch.temperature = '0;
    meas_ch.voltage     = '0;
    meas_ch.chg_present = 1'b0;
    vote_ch.ready       = 1'b0;
    for (phase_no = 0; phase_no < 4; phase_no++) spec_tbl[phase_no] = '0;
    spec_count    = '0;
    float_mv      = '0;
    step_ma       = '0;
    step_ms       = '0;
    tgt_entry     = NONE_YET;
    stp_entry     = NONE_YET;
    last_ma       = '0;
    tick_left     = '0;
    step_armed    = 1'b0;
    meas_taken    = 0;
    ticks_taken   = 0;
    reqs_taken    = 0;
    votes_seen    = 0;
    fail_count    = 0;
    settings_used = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    work_tbl[0] = mk_entry(0, 10, 4200, 500);
    work_tbl[1] = mk_entry(10, 45, 4100, 2000);
    work_tbl[2] = mk_entry(10, 45, 4350, 1000);
    work_tbl[3] = mk_entry(10, 60, 4100, 800);
    program_block(3'd4, 16'd4350, 16'd0, 16'd0);
    @(negedge clk);
    queue_req(OP_MEAS, 25, 3900, 1'b1);
    queue_req(OP_MEAS, 25, 3900, 1'b1);
    queue_req(OP_MEAS, 25, 4200, 1'b1);
    queue_req(OP_MEAS, 25, 4000, 1'b1);
    queue_req(OP_MEAS, 25, 3800, 1'b1);
    queue_req(OP_MEAS, 46, 3800, 1'b1);
    queue_req(OP_MEAS, 44, 3800, 1'b1);
    queue_req(OP_MEAS, 42, 3800, 1'b1);
    queue_req(OP_MEAS, -128, 0, 1'b1);
    queue_req(OP_MEAS, 127, 65535, 1'b1);
    queue_req(OP_TICK, 0, 4000, 1'b1);
    queue_req(OP_MEAS, 5, 4000, 1'b0);
    settle();

    // stepping on: band jump, shared-bound step, retarget while pending
    program_block(3'd4, 16'd4350, 16'd100, 16'd3);
    @(negedge clk);
    queue_req(OP_MEAS, 25, 4200, 1'b1);
    queue_req(OP_MEAS, 25, 3800, 1'b1);
    queue_req(OP_MEAS, 46, 4100, 1'b1);
    queue_req(OP_MEAS, 25, 4200, 1'b1);
    repeat (3) queue_req(OP_TICK, 0, 4200, 1'b1);
    queue_req(OP_MEAS, 46, 4100, 1'b1);
    repeat (3) queue_req(OP_TICK, 0, 3900, 1'b1);
    settle();

    // shrink the table under the target, then disable it
    program_block(3'd2, 16'd4350, 16'd100, 16'd3);
    @(negedge clk);
    queue_req(OP_TICK, 0, 4200, 1'b1);
    queue_req(OP_MEAS, 5, 4000, 1'b1);
    settle();
    program_block(3'd0, 16'd4350, 16'd100, 16'd3);
    @(negedge clk);
    queue_req(OP_MEAS, 25, 3800, 1'b1);
    queue_req(OP_TICK, 0, 4200, 1'b1);
    settle();

    for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) random_phase(phase_no);

    repeat (20) @(posedge clk);
    if (expected_votes.size() != 0) fail_count++;
    $display("Covered %0d measurement and %0d tick requests over %0d table settings.",
             meas_taken, ticks_taken, settings_used);
    $display("%0d votes cast; sink held off for %0d cycles once under load.",
             votes_seen, LONG_STALL_CYCLES);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/ccss_pkg.sv
design/ccss_in_if.sv
design/ccss_out_if.sv
design/ccss_ctrl.sv
design/ccss_datapath.sv
design/charge_current_spec_selector_unit.sv
test/tb_top.sv
